// File: hw/rtl/go_back_n_sender_window_core_macros.svh
// ----------------------------------------------------------------------------
// Go-Back-N sender window core: assertion macros
// Short forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_CORE_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("go-back-n core check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("go-back-n core check failed");

`endif

// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender window package
// Widths, codes and beat types shared by the sender window modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Sizes of the window store and the sequence space.
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned IDX_W      = $clog2(WIN_DEPTH);
  localparam int unsigned CNT_W      = $clog2(WIN_DEPTH + 1);
  localparam int unsigned STAMP_W    = 32;

  // Field and register widths.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CK_W       = 10;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SEQ_BITS_W = 5;
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned TO_W       = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Event kinds of an input beat.
  localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_SENT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACK_OK    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RETX      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TICK_IDLE = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  // Configuration values after reset.
  localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_RST = 5'd3;
  localparam logic [WIN_W-1:0]      WINDOW_RST   = 5'd4;
  localparam logic [TO_W-1:0]       TIMEOUT_RST  = 16'd1000;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_ACK_BAD,
    OP_TICK
  } op_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  ack_seq;
    logic [CK_W-1:0]   ack_checksum;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq;
    logic [SEQ_W-1:0]    window_base;
    logic [CNT_W-1:0]    in_flight;
    logic                last;
  } res_item_t;

  typedef struct packed {
    op_e              op;
    logic [SEQ_W-1:0] ack_seq;
  } cmd_t;

endpackage

// File: hw/rtl/gbn_front.sv
// ----------------------------------------------------------------------------
// Go-Back-N front end
// Accepts event beats, verifies acknowledgment checksums and queues the
// classified commands two deep for the back end.
// ----------------------------------------------------------------------------
module gbn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_push_i,
  input  gbn_pkg::in_item_t in_item_i,
  output logic             in_full_o,
  output logic             cmd_valid_o,
  output gbn_pkg::cmd_t    cmd_o,
  input  logic             cmd_pop_i
);
  import gbn_pkg::*;

  logic [8:0] ck_sum;
  logic       ck_ok;
  logic       keep;
  cmd_t       cmd_new;
  logic       enq;
  logic       deq;

  cmd_t       cmd_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // The checksum is the byte sum of the sequence number.
  assign ck_sum = {1'b0, in_item_i.ack_seq[7:0]} + {1'b0, in_item_i.ack_seq[15:8]};
  assign ck_ok  = ({1'b0, ck_sum} == in_item_i.ack_checksum);

  // Classify the event; the unused kind is accepted and dropped.
  always_comb begin
    keep            = 1'b1;
    cmd_new.op      = OP_TICK;
    cmd_new.ack_seq = in_item_i.ack_seq;
    unique case (in_item_i.kind)
      KIND_SEND: cmd_new.op = OP_SEND;
      KIND_ACK:  cmd_new.op = ck_ok ? OP_ACK : OP_ACK_BAD;
      KIND_TICK: cmd_new.op = OP_TICK;
      default:   keep = 1'b0;
    endcase
  end

  // Two-entry command queue.
  assign in_full_o   = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign enq         = in_push_i && !in_full_o && keep;
  assign deq         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = enq ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (enq) begin
      cmd_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: hw/rtl/gbn_back.sv
// ----------------------------------------------------------------------------
// Go-Back-N back end
// Holds the window state and configuration, executes one command at a time
// and steps through retransmission runs one packet per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module gbn_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            cmd_valid_i,
  input  gbn_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  input  logic                            res_full_i,
  output logic                            res_push_o,
  output gbn_pkg::res_item_t              res_o
);
  import gbn_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RETX
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [SEQ_W-1:0]      base_q, base_d;
  logic [SEQ_W-1:0]      next_q, next_d;
  logic [CNT_W-1:0]      outst_q, outst_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [STAMP_W-1:0]    tick_q, tick_d;

  logic [SEQ_BITS_W-1:0] seq_bits_q;
  logic [WIN_W-1:0]      window_q;
  logic [TO_W-1:0]       timeout_q;

  logic [STAMP_W-1:0]    stamp_q [WIN_DEPTH];
  logic                  stamp_we;
  logic [IDX_W-1:0]      stamp_waddr;

  logic [SEQ_BITS_W-1:0] sb;
  logic [SEQ_W-1:0]      mask;
  logic [SEQ_W-1:0]      half;
  logic [SEQ_W-1:0]      win_lim;
  logic [SEQ_W-1:0]      win_req;
  logic [SEQ_W-1:0]      win_sel;
  logic [CNT_W-1:0]      win_eff;
  logic [TO_W-1:0]       to_eff;

  logic [SEQ_W-1:0]      ack_off;
  logic [CNT_W-1:0]      ack_k;
  logic                  ack_bad;
  logic [STAMP_W-1:0]    tick_nx;
  logic [STAMP_W-1:0]    tick_wait;
  logic                  run_last;
  logic                  geom_wr;

  // Effective sequence width, window and timeout after clamping.
  always_comb begin
    if (seq_bits_q < 5'd2) begin
      sb = 5'd2;
    end else if (seq_bits_q > SEQ_BITS_W'(SEQ_W)) begin
      sb = SEQ_BITS_W'(SEQ_W);
    end else begin
      sb = seq_bits_q;
    end
    mask    = ~({SEQ_W{1'b1}} << sb);
    half    = SEQ_W'(1) << (sb - 5'd1);
    win_lim = (half > SEQ_W'(WIN_DEPTH)) ? SEQ_W'(WIN_DEPTH) : half;
    win_req = (window_q == '0) ? SEQ_W'(1) : SEQ_W'(window_q);
    win_sel = (win_req > win_lim) ? win_lim : win_req;
    win_eff = win_sel[CNT_W-1:0];
    to_eff  = (timeout_q == '0) ? TO_W'(1) : timeout_q;
  end

  // Acknowledgment window test and timeout test.
  assign ack_off   = (cmd_i.ack_seq - base_q) & mask;
  assign ack_bad   = ((cmd_i.ack_seq & ~mask) != '0) || (ack_off >= SEQ_W'(outst_q));
  assign ack_k     = ack_off[CNT_W-1:0] + CNT_W'(1);
  assign tick_nx   = tick_q + STAMP_W'(1);
  assign tick_wait = tick_nx - stamp_q[head_q];
  assign run_last  = (idx_q == outst_q - CNT_W'(1));
  assign geom_wr   = cfg_we_i && ((cfg_idx_i == CFG_SEQ_BITS) || (cfg_idx_i == CFG_WINDOW));

  // Command execution and retransmission sequencing.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    base_d      = base_q;
    next_d      = next_q;
    outst_d     = outst_q;
    head_d      = head_q;
    tick_d      = tick_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    stamp_we    = 1'b0;
    stamp_waddr = head_q;
    res_o.status = ST_TICK_IDLE;
    res_o.seq    = '0;
    res_o.last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          res_push_o = 1'b1;
          unique case (cmd_i.op)
            OP_SEND: begin
              if (outst_q >= win_eff) begin
                res_o.status = ST_FULL;
              end else begin
                stamp_we     = 1'b1;
                stamp_waddr  = head_q + outst_q[IDX_W-1:0];
                outst_d      = outst_q + CNT_W'(1);
                next_d       = (next_q + SEQ_W'(1)) & mask;
                res_o.status = ST_SENT;
                res_o.seq    = next_q & mask;
              end
            end
            OP_ACK_BAD: begin
              res_o.status = ST_CORRUPT;
            end
            OP_ACK: begin
              if (ack_bad) begin
                res_o.status = ST_OUTSIDE;
              end else begin
                outst_d      = outst_q - ack_k;
                base_d       = (base_q + SEQ_W'(ack_k)) & mask;
                head_d       = head_q + ack_k[IDX_W-1:0];
                res_o.status = ST_ACK_OK;
              end
            end
            OP_TICK: begin
              tick_d = tick_nx;
              if ((outst_q != '0) && (tick_wait >= STAMP_W'(to_eff))) begin
                res_push_o = 1'b0;
                state_d    = S_RETX;
                idx_d      = '0;
              end else begin
                res_o.status = ST_TICK_IDLE;
              end
            end
            default: res_o.status = ST_TICK_IDLE;
          endcase
        end
      end
      S_RETX: begin
        // One retransmitted number per beat, restamped with the current tick.
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.status = ST_RETX;
          res_o.seq    = (base_q + SEQ_W'(idx_q)) & mask;
          res_o.last   = run_last;
          stamp_we     = 1'b1;
          stamp_waddr  = head_q + idx_q[IDX_W-1:0];
          idx_d        = idx_q + CNT_W'(1);
          if (run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    res_o.window_base = base_d;
    res_o.in_flight   = outst_d;

    // A change of window geometry restarts the window.
    if (geom_wr) begin
      base_d  = '0;
      next_d  = '0;
      outst_d = '0;
      head_d  = '0;
    end
  end

  // State, window counters and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      base_q     <= '0;
      next_q     <= '0;
      outst_q    <= '0;
      head_q     <= '0;
      tick_q     <= '0;
      seq_bits_q <= SEQ_BITS_RST;
      window_q   <= WINDOW_RST;
      timeout_q  <= TIMEOUT_RST;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      base_q  <= base_d;
      next_q  <= next_d;
      outst_q <= outst_d;
      head_q  <= head_d;
      tick_q  <= tick_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SEQ_BITS: seq_bits_q <= cfg_data_i[SEQ_BITS_W-1:0];
          CFG_WINDOW:   window_q   <= cfg_data_i[WIN_W-1:0];
          CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TO_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  // Send-time stamps, a ring whose head belongs to the oldest packet.
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_q[stamp_waddr] <= tick_q;
    end
  end

endmodule

// File: hw/rtl/gbn_res_q.sv
// ----------------------------------------------------------------------------
// Go-Back-N result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module gbn_res_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gbn_pkg::res_item_t item_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output gbn_pkg::res_item_t item_o
);
  import gbn_pkg::*;

  res_item_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       enq;
  logic       deq;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign enq     = push_i && !full_o;
  assign deq     = pop_i && !empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/go_back_n_sender_window_core.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender window core
// Sender-side window control: numbering of sends, cumulative acknowledgment
// and timeout-driven go-back retransmission.
//
//   Channel   Handshake         Beat
//   -------   ---------------   ---------------------------------------
//   events    push / full       in_item_i: kind, ack_seq, ack_checksum
//   results   empty / pop       res_item_o: status, seq, base, in_flight, last
//   config    cfg_we_i          cfg_idx_i selects, cfg_data_i carries value
//
// Send, acknowledgment and idle tick events each produce one result beat.
// A timed-out tick first decides, then retransmits each outstanding packet
// (up to 16) in turn through the single stamp-store write port.
// Commands queue two deep ahead of the back end and results two deep after it,
// so either side may stall without stopping the other. Reset is asynchronous
// and needs no clearing pass; the stamp ring is only read where written.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  gbn_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output gbn_pkg::res_item_t            res_item_o,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0]     cfg_data_i
);
  import gbn_pkg::*;

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  res_item_t res;

  // Front end: classification and command queue.
  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_push_i   (push),
    .in_item_i   (in_item_i),
    .in_full_o   (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: window state and retransmission.
  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue toward the consumer.
  gbn_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .item_o  (res_item_o)
  );

endmodule

// File: hw/rtl/gbn_checker.sv
// ----------------------------------------------------------------------------
// Go-Back-N core checker
// Port-level checks on the result beats of the sender window core.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_window_core_macros.svh"

module gbn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty_i,
  input logic               pop_i,
  input gbn_pkg::res_item_t res_item_i
);
  import gbn_pkg::*;

  logic res_vld;
  logic seq_used;
  logic is_retx;

  // A result beat is on the ports while the queue is not empty.
  assign res_vld  = !empty_i;
  assign is_retx  = (res_item_i.status == ST_RETX);
  assign seq_used = (res_item_i.status == ST_SENT) || is_retx;

  // A waiting result beat stays put until it is popped.
  `GBN_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_vld && !pop_i, res_vld && $stable(res_item_i))

  // Only sent and retransmitted beats carry a sequence number.
  `GBN_ASSERT_SAME(a_seq_zero, clk_i, rst_ni, res_vld && !seq_used, res_item_i.seq == '0)

  // A retransmission implies at least one packet in flight.
  `GBN_ASSERT_SAME(a_retx_busy, clk_i, rst_ni, res_vld && is_retx, res_item_i.in_flight != '0)

  // The in-flight count never passes the window store size.
  `GBN_ASSERT_SAME(a_flight_cap, clk_i, rst_ni, res_vld, res_item_i.in_flight <= CNT_W'(WIN_DEPTH))

endmodule

bind go_back_n_sender_window_core gbn_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty_i    (empty),
  .pop_i      (pop),
  .res_item_i (res_item_o)
);

// File: tb/tb_go_back_n_sender_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-Back-N sender window core testbench
// Drives send, acknowledgment and tick beats through the event queue and
// checks every result beat against a cycle-free model of the sender window.
// A short directed part covers the window edges and bad acknowledgments;
// random phases then sweep the register settings under varied back-pressure.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_window_core;
  import gbn_pkg::*;

  localparam int unsigned       IN_W          = $bits(in_item_t);
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
  localparam int                SETTLE_CYCLES = 64;
  localparam int                NUM_PHASES    = 6;
  localparam int                PHASE_EVENTS  = 26;
  localparam int                MAX_PRINTS    = 100;

  // An event beat waiting for the driver; drain_first holds it back until
  // every predicted result has been popped.
  typedef struct packed {
    logic     drain_first;
    in_item_t beat;
  } pending_evt_t;

  // Register settings swept by the random phases.
  int ph_seq_bits [NUM_PHASES] = '{3, 2, 16, 0, 31, 4};
  int ph_window   [NUM_PHASES] = '{4, 16, 16, 0, 9, 8};
  int ph_timeout  [NUM_PHASES] = '{3, 1, 5, 0, 65535, 2};
  int ph_send_pct [NUM_PHASES] = '{40, 35, 50, 35, 45, 40};

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 push     = 1'b0;
  logic                 full;
  in_item_t             evt_item = '0;
  logic                 empty;
  logic                 pop      = 1'b0;
  res_item_t            res_item;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Model of the window: configuration and state as seen after each beat.
  logic [SEQ_BITS_W-1:0] cfg_seq_bits = SEQ_BITS_RST;
  logic [WIN_W-1:0]      cfg_window   = WINDOW_RST;
  logic [TO_W-1:0]       cfg_timeout  = TIMEOUT_RST;
  logic [SEQ_W-1:0]      win_base     = '0;
  logic [SEQ_W-1:0]      next_seq     = '0;
  int unsigned           out_cnt      = 0;
  logic [STAMP_W-1:0]    tick_count   = '0;
  logic [STAMP_W-1:0]    stamps [WIN_DEPTH];

  pending_evt_t pending_q [$];
  res_item_t    expected_q [$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int mismatches      = 0;
  int events_accepted = 0;
  int results_checked = 0;
  int retx_seen       = 0;
  int full_seen       = 0;
  int settings_run    = 1;

  go_back_n_sender_window_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (evt_item),
    .empty      (empty),
    .pop        (pop),
    .res_item_o (res_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Sequence numbers wrap at the clamped width.
  function automatic logic [31:0] seq_mask();
    int unsigned b;
    b = cfg_seq_bits;
    if (b < 2) b = 2;
    if (b > SEQ_W) b = SEQ_W;
    return (32'd1 << b) - 32'd1;
  endfunction

  // Effective window: at least one, at most half the space and the store depth.
  function automatic int unsigned win_limit();
    int unsigned half;
    int unsigned w;
    half = (seq_mask() + 1) / 2;
    w    = cfg_window;
    if (w < 1) w = 1;
    if (w > half) w = half;
    if (w > WIN_DEPTH) w = WIN_DEPTH;
    return w;
  endfunction

  function automatic logic [CK_W-1:0] ack_sum(logic [SEQ_W-1:0] a);
    return CK_W'(a[7:0]) + CK_W'(a[15:8]);
  endfunction

  // Expected result beats carry the window state after the event.
  task automatic add_expected(logic [STATUS_W-1:0] st, logic [31:0] s, bit is_last);
    res_item_t r;
    r.status      = st;
    r.seq         = s[SEQ_W-1:0];
    r.window_base = win_base;
    r.in_flight   = CNT_W'(out_cnt);
    r.last        = is_last;
    expected_q.push_back(r);
  endtask

  // Advance the window model by one accepted event beat.
  task automatic predict_event(in_item_t it);
    logic [31:0]        mask;
    logic [31:0]        off;
    logic [31:0]        s;
    logic [STAMP_W-1:0] waited;
    int unsigned        k;
    int unsigned        to;
    mask = seq_mask();
    case (it.kind)
      KIND_SEND: begin
        if (out_cnt >= win_limit()) begin
          add_expected(ST_FULL, 32'd0, 1'b1);
        end else begin
          s                = 32'(next_seq) & mask;
          stamps[out_cnt]  = tick_count;
          out_cnt          = out_cnt + 1;
          next_seq         = SEQ_W'((s + 32'd1) & mask);
          add_expected(ST_SENT, s, 1'b1);
        end
      end
      KIND_ACK: begin
        off = (32'(it.ack_seq) - 32'(win_base)) & mask;
        if (ack_sum(it.ack_seq) != it.ack_checksum) begin
          add_expected(ST_CORRUPT, 32'd0, 1'b1);
        end else if (32'(it.ack_seq) > mask || off >= out_cnt) begin
          add_expected(ST_OUTSIDE, 32'd0, 1'b1);
        end else begin
          // Cumulative: everything up to and including the acked number leaves.
          k = off + 1;
          for (int unsigned i = 0; i + k < out_cnt; i++) stamps[i] = stamps[i + k];
          out_cnt  = out_cnt - k;
          win_base = SEQ_W'((32'(win_base) + k) & mask);
          add_expected(ST_ACK_OK, 32'd0, 1'b1);
        end
      end
      KIND_TICK: begin
        to         = (cfg_timeout == '0) ? 1 : cfg_timeout;
        tick_count = tick_count + 1'b1;
        waited     = tick_count - stamps[0];
        if (out_cnt > 0 && waited >= to) begin
          // Go back: the whole window goes out again, restamped now.
          for (int unsigned i = 0; i < out_cnt; i++) begin
            stamps[i] = tick_count;
            add_expected(ST_RETX, (32'(win_base) + i) & mask, i == out_cnt - 1);
          end
        end else begin
          add_expected(ST_TICK_IDLE, 32'd0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Compare one popped result beat with the oldest expectation.
  task automatic check_result(res_item_t got);
    res_item_t want;
    results_checked++;
    if (got.status == ST_RETX) retx_seen++;
    if (got.status == ST_FULL) full_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected (status %0d)",
                                results_checked, got.status));
    end else begin
      want = expected_q.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_checked, got.status, want.status));
      if (got.seq != want.seq)
        report_mismatch($sformatf("result %0d seq %0d, expected %0d",
                                  results_checked, got.seq, want.seq));
      if (got.window_base != want.window_base)
        report_mismatch($sformatf("result %0d window_base %0d, expected %0d",
                                  results_checked, got.window_base, want.window_base));
      if (got.in_flight != want.in_flight)
        report_mismatch($sformatf("result %0d in_flight %0d, expected %0d",
                                  results_checked, got.in_flight, want.in_flight));
      if (got.last != want.last)
        report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                  results_checked, got.last, want.last));
    end
  endtask

  // Driver: one event beat at a time from the pending queue, with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_event(evt_item);
        events_accepted++;
      end
      if (!push || !full) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            (!pending_q[0].drain_first || expected_q.size() == 0)) begin
          evt_item <= pending_q[0].beat;
          push     <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          evt_item <= in_item_t'(IN_W'($urandom));
          push     <= 1'b0;
        end
      end
    end
  end

  // Monitor: pops result beats with random stalls and checks each one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(res_item);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_event(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] ack,
                             logic [CK_W-1:0] ck, bit hold);
    pending_evt_t p;
    p.drain_first       = hold;
    p.beat.kind         = kind;
    p.beat.ack_seq      = ack;
    p.beat.ack_checksum = ck;
    pending_q.push_back(p);
  endtask

  task automatic queue_ack(logic [SEQ_W-1:0] a);
    queue_event(KIND_ACK, a, ack_sum(a), 1'b0);
  endtask

  task automatic queue_send();
    queue_event(KIND_SEND, SEQ_W'($urandom), CK_W'($urandom), 1'b0);
  endtask

  task automatic queue_tick();
    queue_event(KIND_TICK, SEQ_W'($urandom), CK_W'($urandom), 1'b0);
  endtask

  // Mostly well-formed traffic aimed at the live window, plus some noise.
  task automatic queue_random_event(int send_pct);
    int unsigned      r;
    int unsigned      off;
    logic [SEQ_W-1:0] a;
    logic [CK_W-1:0]  ck;
    bit               hold;
    r    = $urandom_range(99);
    hold = ($urandom_range(99) < 5);
    a    = SEQ_W'($urandom);
    ck   = CK_W'($urandom);
    if (r < send_pct) begin
      queue_event(KIND_SEND, a, ck, hold);
    end else if (r < send_pct + 25) begin
      off = $urandom_range(0, win_limit());
      // Now and then one behind the base, which is a duplicate.
      if ($urandom_range(5) == 0) off = seq_mask();
      a = SEQ_W'((32'(win_base) + off) & seq_mask());
      queue_event(KIND_ACK, a, ack_sum(a), hold);
    end else if (r < send_pct + 45) begin
      queue_event(KIND_TICK, a, ck, hold);
    end else begin
      case ($urandom_range(3))
        0:       queue_event(KIND_ACK, a, ack_sum(a) ^ (CK_W'(1) << $urandom_range(CK_W - 1)),
                             hold);
        1:       queue_event(KIND_ACK, a, ack_sum(a), hold);
        2:       queue_event(KIND_UNUSED, a, ck, hold);
        default: queue_event(KIND_ACK, a, ck, hold);
      endcase
    end
  endtask

  // Register writes happen only with the core idle.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SEQ_BITS) cfg_seq_bits = data[SEQ_BITS_W-1:0];
    if (idx == CFG_WINDOW) cfg_window = data[WIN_W-1:0];
    if (idx == CFG_TIMEOUT) cfg_timeout = data[TO_W-1:0];
    if (idx == CFG_SEQ_BITS || idx == CFG_WINDOW) begin
      win_base = '0;
      next_seq = '0;
      out_cnt  = 0;
    end
  endtask

  // Narrow registers get random junk above their field.
  function automatic logic [CFG_W-1:0] with_junk(int v);
    return (CFG_W'($urandom) & ~CFG_W'(16'h001F)) | CFG_W'(v & 'h1F);
  endfunction

  task automatic write_setting(int sb, int win, int to);
    write_cfg(CFG_SEQ_BITS, with_junk(sb));
    write_cfg(CFG_WINDOW, with_junk(win));
    write_cfg(CFG_TIMEOUT, CFG_W'(to));
    settings_run++;
  endtask

  // Wait for every beat to be sent and every result popped, then settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || push || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 21;
    recv_idle_pct = 69;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: empty window, filling, bad and cumulative acks.
    queue_ack(16'd0);
    queue_tick();
    repeat (5) queue_send();
    queue_event(KIND_ACK, 16'd1, 10'd0, 1'b0);
    queue_ack(16'd9);
    queue_ack(16'd1);
    queue_ack(16'd1);
    queue_ack(16'hFFFF);
    queue_event(KIND_UNUSED, 16'hFFFF, 10'h3FF, 1'b0);
    queue_event(KIND_ACK, 16'd3, ack_sum(16'd3), 1'b1);
    wait_idle();

    // Too-narrow sequence, zero window and zero timeout all clamp.
    write_setting(1, 0, 0);
    queue_send();
    queue_send();
    queue_tick();
    queue_ack(16'd0);
    wait_idle();

    // Too-wide sequence and oversized window clamp to the store depth.
    write_setting(20, 31, 2);
    repeat (3) queue_send();
    queue_tick();
    queue_tick();
    queue_ack(16'hFFFF);
    wait_idle();
    write_cfg(CFG_IDX_W'(3), CFG_W'($urandom));

    // Random phases across the settings table and the idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 69;
      end else if (p < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_setting(ph_seq_bits[p], ph_window[p], ph_timeout[p]);
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        while (pending_q.size() >= 2) @(posedge clk_i);
        queue_random_event(ph_send_pct[p]);
      end
      wait_idle();
    end

    $display("Run covered %0d events over %0d register settings: %0d results checked,",
             events_accepted, settings_run, results_checked);
    $display("including %0d retransmits and %0d full-window refusals; %0d mismatches.",
             retx_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(2_000_000);
    $display("[%0t] timeout with %0d beats unsent and %0d results outstanding",
             $time, pending_q.size(), expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
